### sv/stp_pkg.sv
// Shared types and constants for the scope trigger waveform plotter.
`default_nettype none

package stp_pkg;

	// Item operation codes
	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_DRAW = 1'b1
	} op_t;

	// Configuration port geometry and register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 2'd2;

	// Register reset values
	localparam logic [7:0] Y_SCALE_RST        = 8'd20;
	localparam logic       TRIGGER_ENABLE_RST = 1'b1;
	localparam logic [6:0] WINDOW_LEN_RST     = 7'd64;

	// Window and screen geometry
	localparam int         WIN_W      = 7;
	localparam logic [6:0] MAX_WINDOW = 7'd64;
	localparam int         COORD_W    = 6;
	localparam int         TRIG_W     = 8;
	localparam logic signed [10:0] SCREEN_MID = 11'sd32;
	localparam logic signed [10:0] SCREEN_MAX = 11'sd63;

endpackage

`default_nettype wire

### sv/stp_if.sv
// Valid/ready channel interfaces for sample/draw items and line segments.
`default_nettype none

interface stp_cmd_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	stp_pkg::op_t                  op;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output op, output sample, input ready);
	modport sink (input valid, input op, input sample, output ready);
endinterface

interface stp_seg_if;
	logic                            valid;
	logic                            ready;
	logic [stp_pkg::COORD_W-1:0]     x_start;
	logic [stp_pkg::COORD_W-1:0]     y_start;
	logic [stp_pkg::COORD_W-1:0]     y_end;
	logic [stp_pkg::TRIG_W-1:0]      trigger_pos;
	logic                            last;

	modport source (output valid, output x_start, output y_start, output y_end,
		output trigger_pos, output last, input ready);
	modport sink (input valid, input x_start, input y_start, input y_end,
		input trigger_pos, input last, output ready);
endinterface

`default_nettype wire

### sv/scope_trigger_waveform_plotter.sv
// Scope plotter: sample ring, rising zero-crossing trigger and segment output.
// Push item: one push per cycle back to back while idle; no result.
// Draw item, window n (1..64): the search reads up to n+1 positions (read, compare),
// the frame n+1 positions (read, multiply, row), with no search when the trigger is
// off; the input is held until the frame ends, output stalls included; one read port.
// Reset clears control state and loads register defaults; a fill count zeroes unwritten reads.
`default_nettype none

module scope_trigger_waveform_plotter #(
	parameter int RING_DEPTH  = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [stp_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire [stp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	stp_cmd_if.sink                         cmd,
	stp_seg_if.source                       seg
);

	localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int PW     = SAMPLE_BITS + 9;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_DRAW_RD,
		ST_DRAW_MUL,
		ST_DRAW_ROW
	} state_t;

	// Ring storage
	logic signed [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];

	state_t                          state_q;
	logic [IDX_W-1:0]                head_q;
	logic [FILL_W-1:0]               fill_q;
	logic [IDX_W-1:0]                trig_q;
	logic [IDX_W-1:0]                rd_addr_q;
	logic [IDX_W-1:0]                prev_addr_q;
	logic                            prev_neg_q;
	logic [stp_pkg::COORD_W-1:0]     prev_row_q;
	logic [stp_pkg::WIN_W-1:0]       k_q;
	logic [stp_pkg::WIN_W-1:0]       n_q;
	logic [7:0]                      y_scale_q;
	logic                            trig_en_q;
	logic [stp_pkg::WIN_W-1:0]       win_len_q;
	logic signed [SAMPLE_BITS-1:0]   rd_data_s1;
	logic                            rd_ok_s1;
	logic signed [PW-1:0]            prod_s1;
	logic                            out_valid_q;
	logic [stp_pkg::COORD_W-1:0]     out_x_q;
	logic [stp_pkg::COORD_W-1:0]     out_ys_q;
	logic [stp_pkg::COORD_W-1:0]     out_ye_q;
	logic [stp_pkg::TRIG_W-1:0]      out_trig_q;
	logic                            out_last_q;

	logic                            cmd_acc;
	logic                            slot_free;
	logic                            seg_load;
	logic signed [SAMPLE_BITS-1:0]   eff_sample;
	logic [stp_pkg::WIN_W-1:0]       n_eff;
	logic [IDX_W-1:0]                head_nxt;
	logic [IDX_W-1:0]                rd_addr_nxt;
	logic signed [PW-1:0]            prod_bias;
	logic signed [9:0]               q_row;
	logic signed [10:0]              y_row;
	logic [stp_pkg::COORD_W-1:0]     row;

	// Handshake and helpers
	assign cmd.ready   = (state_q == ST_IDLE);
	assign cmd_acc     = cmd.valid && cmd.ready;
	assign slot_free   = !out_valid_q || seg.ready;
	assign seg_load    = (state_q == ST_DRAW_ROW) && (k_q != '0) && slot_free;
	assign eff_sample  = rd_ok_s1 ? rd_data_s1 : '0;
	assign n_eff       = (win_len_q > stp_pkg::MAX_WINDOW) ? stp_pkg::MAX_WINDOW : win_len_q;
	assign head_nxt    = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign rd_addr_nxt = (rd_addr_q == LAST_IDX) ? '0 : rd_addr_q + 1'b1;

	// Row of a sample: truncate product toward zero, offset and clamp
	assign prod_bias = prod_s1[PW-1] ? PW'((1 << (SAMPLE_BITS - 1)) - 1) : '0;
	always_comb begin
		logic signed [PW-1:0] sum;
		sum   = prod_s1 + prod_bias;
		q_row = sum[PW-1:SAMPLE_BITS-1];
		y_row = stp_pkg::SCREEN_MID - 11'(q_row);
		if (y_row < 11'sd0) begin
			row = '0;
		end else if (y_row > stp_pkg::SCREEN_MAX) begin
			row = stp_pkg::COORD_W'(stp_pkg::SCREEN_MAX);
		end else begin
			row = y_row[stp_pkg::COORD_W-1:0];
		end
	end

	// Write pushed samples; read one entry a cycle with registered data
	always_ff @(posedge clk) begin
		if (cmd_acc && cmd.op == stp_pkg::OP_PUSH) begin
			ring_mem[head_q] <= cmd.sample;
		end
		rd_data_s1 <= ring_mem[rd_addr_q];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_scale_q <= stp_pkg::Y_SCALE_RST;
			trig_en_q <= stp_pkg::TRIGGER_ENABLE_RST;
			win_len_q <= stp_pkg::WINDOW_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				stp_pkg::CFG_Y_SCALE:        y_scale_q <= cfg_wdata;
				stp_pkg::CFG_TRIGGER_ENABLE: trig_en_q <= cfg_wdata[0];
				stp_pkg::CFG_WINDOW_LEN:     win_len_q <= cfg_wdata[stp_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Payload pipeline registers
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAW_MUL) begin
			prod_s1 <= PW'(eff_sample) * $signed({1'b0, y_scale_q});
		end
		if (seg_load) begin
			out_x_q    <= stp_pkg::COORD_W'(k_q - 1'b1);
			out_ys_q   <= prev_row_q;
			out_ye_q   <= row;
			out_trig_q <= stp_pkg::TRIG_W'(trig_q);
			out_last_q <= (k_q == n_q);
		end
	end

	// Sequencer: push, trigger search, frame draw
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			trig_q      <= '0;
			rd_addr_q   <= '0;
			prev_addr_q <= '0;
			prev_neg_q  <= 1'b0;
			prev_row_q  <= '0;
			k_q         <= '0;
			n_q         <= '0;
			rd_ok_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_ok_s1 <= (FILL_W'(rd_addr_q) < fill_q);
			if (seg.ready) begin
				out_valid_q <= 1'b0;
			end
			if (seg_load) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc && cmd.op == stp_pkg::OP_PUSH) begin
						head_q <= head_nxt;
						if (fill_q != FILL_W'(RING_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
					end else if (cmd_acc && n_eff != '0) begin
						n_q <= n_eff;
						k_q <= '0;
						if (trig_en_q) begin
							rd_addr_q <= head_nxt;
							state_q   <= ST_SRCH_RD;
						end else begin
							rd_addr_q <= trig_q;
							state_q   <= ST_DRAW_RD;
						end
					end
				end
				ST_SRCH_RD: begin
					state_q <= ST_SRCH_CMP;
				end
				ST_SRCH_CMP: begin
					prev_neg_q  <= eff_sample[SAMPLE_BITS-1];
					prev_addr_q <= rd_addr_q;
					if (k_q != '0 && prev_neg_q && !eff_sample[SAMPLE_BITS-1]) begin
						trig_q    <= prev_addr_q;
						rd_addr_q <= prev_addr_q;
						k_q       <= '0;
						state_q   <= ST_DRAW_RD;
					end else if (k_q == n_q) begin
						rd_addr_q <= trig_q;
						k_q       <= '0;
						state_q   <= ST_DRAW_RD;
					end else begin
						rd_addr_q <= rd_addr_nxt;
						k_q       <= k_q + 1'b1;
						state_q   <= ST_SRCH_RD;
					end
				end
				ST_DRAW_RD: begin
					state_q <= ST_DRAW_MUL;
				end
				ST_DRAW_MUL: begin
					state_q <= ST_DRAW_ROW;
				end
				ST_DRAW_ROW: begin
					if (k_q == '0 || slot_free) begin
						prev_row_q <= row;
						if (k_q == n_q) begin
							state_q <= ST_IDLE;
						end else begin
							rd_addr_q <= rd_addr_nxt;
							k_q       <= k_q + 1'b1;
							state_q   <= ST_DRAW_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output ports
	assign seg.valid       = out_valid_q;
	assign seg.x_start     = out_x_q;
	assign seg.y_start     = out_ys_q;
	assign seg.y_end       = out_ye_q;
	assign seg.trigger_pos = out_trig_q;
	assign seg.last        = out_last_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RING_DEPTH))
		else $error("fill count beyond ring depth");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(FILL_W'(head_q) < FILL_W'(RING_DEPTH)) && (FILL_W'(rd_addr_q) < FILL_W'(RING_DEPTH))
		&& (FILL_W'(trig_q) < FILL_W'(RING_DEPTH)))
		else $error("ring index out of range");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (k_q <= n_q && n_q != '0 && n_q <= stp_pkg::MAX_WINDOW))
		else $error("position counter beyond window");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_load && k_q == n_q) |=> (state_q == ST_IDLE && out_valid_q && out_last_q))
		else $error("final segment did not end the frame");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !seg.ready) |=> $stable(out_x_q) && $stable(out_ye_q))
		else $error("pending segment overwritten");

endmodule

`default_nettype wire

### bench/scope_trigger_waveform_plotter_tb.sv
// Self-checking testbench for the scope trigger waveform plotter against a frame predictor.
`timescale 1ns / 1ps

module scope_trigger_waveform_plotter_tb;

	localparam int SAMPLE_W      = 16;
	localparam int RING_SIZE     = 256;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 76;
	localparam int DRAW_PERCENT  = 12;
	localparam int SETTLE_CYCLES = 400;
	localparam int HOLD_CYCLES   = 800;
	localparam int QUIET_LIMIT   = 5000;

	// Index past the last register; writes there must change nothing
	localparam logic [stp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [stp_pkg::COORD_W-1:0] x_start;
		logic [stp_pkg::COORD_W-1:0] y_start;
		logic [stp_pkg::COORD_W-1:0] y_end;
		logic [stp_pkg::TRIG_W-1:0]  trigger_pos;
		logic                        last;
	} segment_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t                      kind;
		stp_pkg::op_t                   op;
		logic signed [15:0]             sample;
		logic [stp_pkg::CFG_IDX_W-1:0]  reg_idx;
		logic [stp_pkg::CFG_DATA_W-1:0] reg_data;
		logic                           typed;
		logic [stp_pkg::COORD_W-1:0]    want_row;
		logic [stp_pkg::TRIG_W-1:0]     want_trig;
	} plan_row_t;

	typedef enum logic [2:0] {
		SHAPE_NOISE,
		SHAPE_EXTREME,
		SHAPE_NEAR_ZERO,
		SHAPE_POSITIVE,
		SHAPE_NEGATIVE
	} shape_t;

	// Directed stimulus; typed rows pin every row and trigger of the frame
	localparam int PLAN_ROWS = 25;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_ITEM, stp_pkg::OP_DRAW, 16'sh0000, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b1, 6'd32, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_PUSH, 16'sh8000, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_PUSH, 16'sh7FFF, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_PUSH, 16'shFFFF, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_PUSH, 16'sh0000, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_PUSH, 16'sh0001, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_PUSH, 16'sh4000, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_PUSH, 16'shC000, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_REG, stp_pkg::OP_PUSH, 16'sh0000, stp_pkg::CFG_WINDOW_LEN, 8'd9, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_DRAW, 16'sh0000, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_REG, stp_pkg::OP_PUSH, 16'sh0000, stp_pkg::CFG_Y_SCALE, 8'd0, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_DRAW, 16'sh0000, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b1, 6'd32, 8'd0},
		'{ROW_REG, stp_pkg::OP_PUSH, 16'sh0000, stp_pkg::CFG_Y_SCALE, 8'd255, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_DRAW, 16'sh0000, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_REG, stp_pkg::OP_PUSH, 16'sh0000, stp_pkg::CFG_WINDOW_LEN, 8'd0, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_DRAW, 16'sh0000, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_REG, stp_pkg::OP_PUSH, 16'sh0000, stp_pkg::CFG_WINDOW_LEN, 8'd1, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_DRAW, 16'sh0000, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_REG, stp_pkg::OP_PUSH, 16'sh0000, stp_pkg::CFG_WINDOW_LEN, 8'hFF, 1'b0, 6'd0, 8'd0},
		'{ROW_REG, stp_pkg::OP_PUSH, 16'sh0000, stp_pkg::CFG_TRIGGER_ENABLE, 8'hFE, 1'b0, 6'd0,
			8'd0},
		'{ROW_REG, stp_pkg::OP_PUSH, 16'sh0000, stp_pkg::CFG_Y_SCALE, 8'd1, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_DRAW, 16'sh0000, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_REG, stp_pkg::OP_PUSH, 16'sh0000, CFG_SPARE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_ITEM, stp_pkg::OP_DRAW, 16'sh0000, stp_pkg::CFG_Y_SCALE, 8'h00, 1'b0, 6'd0, 8'd0},
		'{ROW_REG, stp_pkg::OP_PUSH, 16'sh0000, stp_pkg::CFG_TRIGGER_ENABLE, 8'h01, 1'b0, 6'd0,
			8'd0}
	};

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [stp_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [stp_pkg::CFG_DATA_W-1:0] cfg_wdata;

	stp_cmd_if #(.SAMPLE_BITS(SAMPLE_W)) cmd_ch ();
	stp_seg_if                           seg_ch ();

	scope_trigger_waveform_plotter #(
		.RING_DEPTH  (RING_SIZE),
		.SAMPLE_BITS (SAMPLE_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.seg       (seg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the block state and registers
	logic signed [SAMPLE_W-1:0] ring_mirror [RING_SIZE];
	logic [7:0]                 head_mirror;
	logic [7:0]                 trigger_mirror;
	logic [7:0]                 gain_reg;
	logic                       arm_reg;
	logic [6:0]                 window_reg;

	segment_t pending_segs [$];
	int       mismatches = 0;
	int       quiet = 0;
	bit       hold_req = 1'b0;
	bit       steady_source = 1'b0;
	shape_t   shape = SHAPE_NOISE;
	int       shape_left = 0;

	task automatic log_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want,
			input segment_t ref_seg);
		if (got !== want)
			log_mismatch($sformatf("%s got %0d want %0d (trigger %0d, column %0d)",
				name, got, want, ref_seg.trigger_pos, ref_seg.x_start));
	endtask

	// Screen row of one sample: 32 minus the truncated scaled value, clamped
	function automatic logic [stp_pkg::COORD_W-1:0] screen_row(
			input logic signed [SAMPLE_W-1:0] s);
		int q;
		int row;
		q = (int'(s) * int'(gain_reg)) / (1 << (SAMPLE_W - 1));
		row = int'(stp_pkg::SCREEN_MID) - q;
		if (row < 0)
			row = 0;
		if (row > int'(stp_pkg::SCREEN_MAX))
			row = int'(stp_pkg::SCREEN_MAX);
		return row[stp_pkg::COORD_W-1:0];
	endfunction

	// Apply one item to the mirror and queue the segments it draws
	function automatic int predict_item(input stp_pkg::op_t op,
			input logic signed [SAMPLE_W-1:0] smp);
		int         n;
		logic [7:0] i;
		logic [7:0] j;
		segment_t   s;
		if (op == stp_pkg::OP_PUSH) begin
			ring_mirror[head_mirror] = smp;
			head_mirror = head_mirror + 8'd1;
			return 0;
		end
		n = (window_reg > stp_pkg::MAX_WINDOW) ? int'(stp_pkg::MAX_WINDOW) : int'(window_reg);
		// search the oldest samples for a negative to nonnegative step
		if (arm_reg) begin
			for (int k = 0; k < n; k++) begin
				i = 8'(int'(head_mirror) + 1 + k);
				j = i + 8'd1;
				if (ring_mirror[i] < 0 && ring_mirror[j] >= 0) begin
					trigger_mirror = i;
					break;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			i = 8'(int'(trigger_mirror) + k);
			j = i + 8'd1;
			s.x_start     = k[stp_pkg::COORD_W-1:0];
			s.y_start     = screen_row(ring_mirror[i]);
			s.y_end       = screen_row(ring_mirror[j]);
			s.trigger_pos = trigger_mirror;
			s.last        = (k == n - 1);
			pending_segs.push_back(s);
		end
		return n;
	endfunction

	// Mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 48);
	endfunction

	// Samples come in runs of one shape so crossings and flat stretches both occur
	function automatic logic signed [SAMPLE_W-1:0] next_sample();
		logic [SAMPLE_W-1:0] raw;
		if (shape_left == 0) begin
			shape = shape_t'($urandom_range(0, 4));
			shape_left = $urandom_range(3, 80);
		end
		shape_left--;
		raw = SAMPLE_W'($urandom);
		case (shape)
			SHAPE_EXTREME: begin
				case ($urandom_range(0, 5))
					0: raw = 16'h8000;
					1: raw = 16'h7FFF;
					2: raw = 16'h0000;
					3: raw = 16'hFFFF;
					4: raw = 16'h0001;
					default: raw = 16'h8001;
				endcase
			end
			SHAPE_NEAR_ZERO: raw = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
			SHAPE_POSITIVE:  raw[SAMPLE_W-1] = 1'b0;
			SHAPE_NEGATIVE:  raw[SAMPLE_W-1] = 1'b1;
			default: ;
		endcase
		return raw;
	endfunction

	// Offer one item after a random gap (none for a steady source) and predict it once taken
	task automatic send_item(input stp_pkg::op_t op, input logic signed [SAMPLE_W-1:0] smp,
			output int added);
		int gap;
		gap = steady_source ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.op     <= op;
		cmd_ch.sample <= smp;
		do @(posedge clk); while (!cmd_ch.ready);
		added = predict_item(op, smp);
	endtask

	// Drop valid and hold until every queued segment has come back
	task automatic wait_empty();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending_segs.size() != 0)
			@(posedge clk);
	endtask

	// Drain, then give a draw that produces nothing time to finish
	task automatic settle();
		wait_empty();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [stp_pkg::CFG_IDX_W-1:0] idx,
			input logic [stp_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		case (idx)
			stp_pkg::CFG_Y_SCALE:        gain_reg = data;
			stp_pkg::CFG_TRIGGER_ENABLE: arm_reg = data[0];
			stp_pkg::CFG_WINDOW_LEN:     window_reg = data[6:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Segment receiver: random stalls, no-stall runs and one long hold-off
	initial begin : seg_sink
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left = 0;
		seg_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				seg_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (run_left > 0) begin
				seg_ch.ready <= 1'b1;
				run_left--;
			end else if (stall_left > 0) begin
				seg_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				seg_ch.ready <= 1'b1;
				if ($urandom_range(0, 9) == 0)
					run_left = $urandom_range(20, 200);
				else
					stall_left = pick_gap();
			end
		end
	end

	// Compare each taken segment with the oldest queued one
	always @(posedge clk) begin : seg_check
		segment_t got;
		segment_t want;
		if (arst_n && seg_ch.valid && seg_ch.ready) begin
			got = {seg_ch.x_start, seg_ch.y_start, seg_ch.y_end, seg_ch.trigger_pos,
				seg_ch.last};
			if (pending_segs.size() == 0) begin
				log_mismatch($sformatf("segment with no frame pending: trigger %0d column %0d",
					got.trigger_pos, got.x_start));
			end else begin
				want = pending_segs.pop_front();
				cmp_field("x_start", 8'(got.x_start), 8'(want.x_start), want);
				cmp_field("y_start", 8'(got.y_start), 8'(want.y_start), want);
				cmp_field("y_end", 8'(got.y_end), 8'(want.y_end), want);
				cmp_field("trigger_pos", got.trigger_pos, want.trigger_pos, want);
				cmp_field("last", 8'(got.last), 8'(want.last), want);
			end
		end
	end

	// Abort when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (seg_ch.valid && seg_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int           added;
		int           first;
		bit           dirty;
		bit           hold_pending;
		stp_pkg::op_t op;
		logic [6:0]   win;
		logic         arm;
		logic [7:0]   gain;
		logic [7:0]   noise;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = stp_pkg::CFG_Y_SCALE;
		cfg_wdata     = '0;
		cmd_ch.valid  = 1'b0;
		cmd_ch.op     = stp_pkg::OP_PUSH;
		cmd_ch.sample = '0;
		foreach (ring_mirror[a])
			ring_mirror[a] = '0;
		head_mirror    = '0;
		trigger_mirror = '0;
		gain_reg       = stp_pkg::Y_SCALE_RST;
		arm_reg        = stp_pkg::TRIGGER_ENABLE_RST;
		window_reg     = stp_pkg::WINDOW_LEN_RST;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table; register rows wait for the block to go idle
		dirty = 1'b0;
		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (PLAN[r].kind == ROW_REG) begin
				if (dirty) begin
					settle();
					dirty = 1'b0;
				end
				set_reg(PLAN[r].reg_idx, PLAN[r].reg_data);
			end else begin
				send_item(PLAN[r].op, PLAN[r].sample, added);
				dirty = 1'b1;
				if (PLAN[r].typed) begin
					first = pending_segs.size() - added;
					for (int e = first; e < pending_segs.size(); e++) begin
						pending_segs[e].y_start     = PLAN[r].want_row;
						pending_segs[e].y_end       = PLAN[r].want_row;
						pending_segs[e].trigger_pos = PLAN[r].want_trig;
					end
				end
			end
		end

		// Random phases, each under a fresh register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case ($urandom_range(0, 5))
				0: gain = 8'd255;
				1: gain = 8'd0;
				2: gain = 8'd1;
				default: gain = 8'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 19))
				0: win = 7'd0;
				1, 2: win = 7'($urandom_range(65, 127));
				3, 4: win = 7'd64;
				5: win = 7'd1;
				default: win = 7'($urandom_range(1, 63));
			endcase
			arm = ($urandom_range(0, 3) != 0);
			// the long hold-off phase needs full frames
			if (ph == 1) begin
				win = 7'd64;
				arm = 1'b1;
			end
			set_reg(stp_pkg::CFG_Y_SCALE, gain);
			noise = 8'($urandom);
			noise[0] = arm;
			set_reg(stp_pkg::CFG_TRIGGER_ENABLE, noise);
			noise = 8'($urandom);
			noise[6:0] = win;
			set_reg(stp_pkg::CFG_WINDOW_LEN, noise);

			steady_source = (ph == 4) || ($urandom_range(0, 3) == 0);
			hold_pending = (ph == 1);
			for (int it = 0; it < PHASE_ITEMS; it++) begin
				if (ph == 3 && it == PHASE_ITEMS / 2)
					wait_empty();
				if (hold_pending && it == 0)
					op = stp_pkg::OP_DRAW;
				else
					op = ($urandom_range(0, 99) < DRAW_PERCENT) ? stp_pkg::OP_DRAW
						: stp_pkg::OP_PUSH;
				send_item(op, next_sample(), added);
				// stall the receiver behind a full frame while items keep coming
				if (hold_pending && op == stp_pkg::OP_DRAW) begin
					hold_req = 1'b1;
					hold_pending = 1'b0;
				end
			end
		end

		settle();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
